[sv/rbc_pkg.sv]
// ----------------------------------------------------------------------------
// rbc_pkg: shared constants for the resonant biquad controller
// Fixed-point formats, datapath widths and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package rbc_pkg;

  // Field and format widths
  localparam int SAMPLE_W   = 16;  // integer samples
  localparam int COEF_W     = 32;  // Q8.24 coefficients
  localparam int COEF_FRAC  = 24;
  localparam int STATE_W    = 48;  // Q32.16 history
  localparam int STATE_FRAC = 16;

  // Shared multiplier: coefficient times one half of a history word
  localparam int HALF_W = STATE_W / 2;
  localparam int PROD_W = COEF_W + HALF_W + 1;

  // Accumulator holds the exact sum of three full products plus headroom
  localparam int ACC_W = COEF_W + STATE_W + 4;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_B0 = 3'd0,
    REG_COEF_B1 = 3'd1,
    REG_COEF_B2 = 3'd2,
    REG_COEF_A1 = 3'd3,
    REG_COEF_A2 = 3'd4,
    REG_OUT_MIN = 3'd5,
    REG_OUT_MAX = 3'd6,
    REG_ENABLE  = 3'd7
  } cfg_reg_e;

endpackage

`default_nettype wire

[sv/resonant_biquad_controller.sv]
// ----------------------------------------------------------------------------
// resonant_biquad_controller: quasi-PR controller step, direct-form-II biquad
// Error = reference - feedback, w0 = error - a1*w1 - a2*w2 (saturated),
// out = b0*w0 + b1*w1 + b2*w2 clamped to [out_min, out_max].
// ----------------------------------------------------------------------------
// A sample transfer starts one controller step; the block drops in_ready_o
// until the step is finished and its result is in the output register. A
// normal step runs ten partial products on the single 32x25 signed
// multiplier (five coefficient-times-history products, each split into a
// low and a high half of the 48-bit history word) with their accumulation
// overlapped; each of the two product passes then adds in its last product,
// ST_W0 saturates w0, and ST_DONE clamps and loads the result. The next
// sample is taken in the cycle the result appears. A clear command or a
// sample taken while enable is low goes straight to ST_DONE and returns 0.
// The output register lets the next sample be taken while a result waits;
// the step after that stalls in its last cycle until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module resonant_biquad_controller (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // sample channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 cmd_i,
  input  wire logic signed [rbc_pkg::SAMPLE_W-1:0]  reference_i,
  input  wire logic signed [rbc_pkg::SAMPLE_W-1:0]  feedback_i,
  // result channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed [rbc_pkg::SAMPLE_W-1:0]       control_out_o,
  // configuration write port
  input  wire logic                                 cfg_we_i,
  input  wire logic [rbc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [rbc_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  localparam int SW    = rbc_pkg::SAMPLE_W;
  localparam int CW    = rbc_pkg::COEF_W;
  localparam int HW    = rbc_pkg::STATE_W;
  localparam int HALF  = rbc_pkg::HALF_W;
  localparam int PW    = rbc_pkg::PROD_W;
  localparam int AW    = rbc_pkg::ACC_W;
  localparam int CFRAC = rbc_pkg::COEF_FRAC;
  localparam int RSH   = rbc_pkg::COEF_FRAC + rbc_pkg::STATE_FRAC;
  localparam int RES_W = AW - RSH;

  // Step counter: the first pass ends after four products, the second after ten
  localparam logic [3:0] STEP_W0_END  = 4'd4;
  localparam logic [3:0] STEP_OUT_END = 4'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FBK,    // feedback products a1*w1, a2*w2
    ST_W0,     // saturate w0
    ST_FWD,    // feedforward products b0*w0, b1*w1, b2*w2
    ST_DONE    // clamp and load output register
  } state_e;

  // Product pairs, selected by step[3:1]
  typedef enum logic [2:0] {
    OP_A1W1 = 3'd0,
    OP_A2W2 = 3'd1,
    OP_B0W0 = 3'd2,
    OP_B1W1 = 3'd3,
    OP_B2W2 = 3'd4
  } op_e;

  // Configuration registers
  logic signed [CW-1:0] coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;
  logic signed [SW-1:0] out_min_q, out_max_q;
  logic                 enable_q;

  // Controller state and datapath registers
  state_e               state_q;
  logic [3:0]           step_q;
  logic                 zero_q;
  logic signed [HW-1:0] hist_one_q, hist_two_q, w0_q;
  logic signed [AW-1:0] acc_q;
  logic signed [PW-1:0] prod_q;
  logic                 prod_hi_q;
  logic                 out_valid_q;
  logic signed [SW-1:0] out_q;

  logic signed [CW-1:0]   mul_a;
  logic signed [HW-1:0]   hist_sel;
  logic signed [HALF:0]   mul_b;
  logic signed [PW-1:0]   mul_p;
  logic signed [AW-1:0]   term;
  logic signed [SW:0]     err;
  logic signed [AW-1:0]   err_acc;
  logic                   w0_in_range;
  logic signed [HW-1:0]   w0_sat;
  logic signed [RES_W-1:0] res;
  logic signed [SW-1:0]   res_clamp;
  logic                   issue;
  logic                   out_free;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign control_out_o = out_q;
  assign out_free      = !out_valid_q || out_ready_i;

  // Operand select for the shared multiplier
  always_comb begin
    unique case (op_e'(step_q[3:1]))
      OP_A1W1: begin mul_a = coef_a1_q; hist_sel = hist_one_q; end
      OP_A2W2: begin mul_a = coef_a2_q; hist_sel = hist_two_q; end
      OP_B0W0: begin mul_a = coef_b0_q; hist_sel = w0_q;       end
      OP_B1W1: begin mul_a = coef_b1_q; hist_sel = hist_one_q; end
      OP_B2W2: begin mul_a = coef_b2_q; hist_sel = hist_two_q; end
      default: begin mul_a = '0;        hist_sel = '0;         end
    endcase
  end

  // Low half is unsigned, high half carries the sign
  assign mul_b = step_q[0] ? {hist_sel[HW-1], hist_sel[HW-1:HALF]}
                           : {1'b0, hist_sel[HALF-1:0]};
  assign mul_p = mul_a * mul_b;

  // Registered partial product, weighted by its half
  assign term = prod_hi_q ? (AW'(prod_q) <<< HALF) : AW'(prod_q);

  assign issue = ((state_q == ST_FBK) && (step_q != STEP_W0_END)) ||
                 ((state_q == ST_FWD) && (step_q != STEP_OUT_END));

  // Error aligned to the Q.(24+16) accumulator
  assign err     = (SW+1)'(reference_i) - (SW+1)'(feedback_i);
  assign err_acc = AW'(err) <<< RSH;

  // w0 saturation to the history range
  assign w0_in_range = (&acc_q[AW-1:CFRAC+HW-1]) || !(|acc_q[AW-1:CFRAC+HW-1]);
  assign w0_sat = w0_in_range ? acc_q[CFRAC+HW-1:CFRAC]
                              : {acc_q[AW-1], {(HW-1){!acc_q[AW-1]}}};

  // Output clamp, upper limit first
  assign res = acc_q[AW-1:RSH];
  always_comb begin
    if (res > RES_W'(out_max_q)) begin
      res_clamp = out_max_q;
    end else if (res < RES_W'(out_min_q)) begin
      res_clamp = out_min_q;
    end else begin
      res_clamp = res[SW-1:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_b0_q <= '0;
      coef_b1_q <= '0;
      coef_b2_q <= '0;
      coef_a1_q <= '0;
      coef_a2_q <= '0;
      out_min_q <= {1'b1, {(SW-1){1'b0}}};
      out_max_q <= {1'b0, {(SW-1){1'b1}}};
      enable_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (rbc_pkg::cfg_reg_e'(cfg_idx_i))
        rbc_pkg::REG_COEF_B0: coef_b0_q <= cfg_wdata_i[CW-1:0];
        rbc_pkg::REG_COEF_B1: coef_b1_q <= cfg_wdata_i[CW-1:0];
        rbc_pkg::REG_COEF_B2: coef_b2_q <= cfg_wdata_i[CW-1:0];
        rbc_pkg::REG_COEF_A1: coef_a1_q <= cfg_wdata_i[CW-1:0];
        rbc_pkg::REG_COEF_A2: coef_a2_q <= cfg_wdata_i[CW-1:0];
        rbc_pkg::REG_OUT_MIN: out_min_q <= cfg_wdata_i[SW-1:0];
        rbc_pkg::REG_OUT_MAX: out_max_q <= cfg_wdata_i[SW-1:0];
        rbc_pkg::REG_ENABLE:  enable_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      zero_q      <= 1'b0;
      hist_one_q  <= '0;
      hist_two_q  <= '0;
      w0_q        <= '0;
      acc_q       <= '0;
      prod_q      <= '0;
      prod_hi_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // drain the result slot unless a new result is loaded this cycle
      if (out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      // one product per cycle while issue is set, accumulated from prod_q in the next cycle
      if (issue) begin
        prod_q    <= mul_p;
        prod_hi_q <= step_q[0];
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            step_q <= '0;
            acc_q  <= err_acc;
            if (cmd_i) begin
              hist_one_q <= '0;
              hist_two_q <= '0;
              zero_q     <= 1'b1;
              state_q    <= ST_DONE;
            end else if (!enable_q) begin
              zero_q  <= 1'b1;
              state_q <= ST_DONE;
            end else begin
              zero_q  <= 1'b0;
              state_q <= ST_FBK;
            end
          end
        end
        ST_FBK: begin
          if (step_q != '0) begin
            acc_q <= acc_q - term;
          end
          step_q <= step_q + 4'd1;
          if (step_q == STEP_W0_END) begin
            state_q <= ST_W0;
          end
        end
        ST_W0: begin
          w0_q    <= w0_sat;
          acc_q   <= '0;
          step_q  <= STEP_W0_END;
          state_q <= ST_FWD;
        end
        ST_FWD: begin
          if (step_q != STEP_W0_END) begin
            acc_q <= acc_q + term;
          end
          step_q <= step_q + 4'd1;
          if (step_q == STEP_OUT_END) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_q       <= zero_q ? '0 : res_clamp;
            out_valid_q <= 1'b1;
            if (!zero_q) begin
              hist_two_q <= hist_one_q;
              hist_one_q <= w0_q;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/rbc_checker.sv]
// ----------------------------------------------------------------------------
// rbc_checker: port-level checks for the resonant biquad controller
// Watches the handshakes and the result of clear commands.
// ----------------------------------------------------------------------------
`default_nettype none

module rbc_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_o,
  input wire logic                                cmd_i,
  input wire logic                                out_valid_o,
  input wire logic                                out_ready_i,
  input wire logic signed [rbc_pkg::SAMPLE_W-1:0] control_out_o
);

  // No result is offered while in reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(control_out_o))
    else $error("stalled result changed or dropped");

  // One sample at a time: after a transfer the block is busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sample taken while a step is running");

  // A clear command with a free output slot returns zero, loaded from ST_DONE
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i && !out_valid_o
    |=> ##1 out_valid_o && (control_out_o == '0))
    else $error("clear command did not return zero");

endmodule

bind resonant_biquad_controller rbc_checker u_rbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .cmd_i         (cmd_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .control_out_o (control_out_o)
);

`default_nettype wire
